>>> rtl/flex_bend_detector_core_defines.svh
// Assertion macros used by the checker file.
`ifndef FLEX_BEND_DETECTOR_CORE_DEFINES_SVH
`define FLEX_BEND_DETECTOR_CORE_DEFINES_SVH
// Implication check with a label and a message.
`define FBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check.
`define FBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/fbd_pkg.sv
// Package: widths, register indexes and defaults of the flex bend detector.
`default_nettype none
package fbd_pkg;
  localparam int MAX_WINDOW = 25;
  localparam int SAMPLE_BITS = 10;
  localparam int SMOOTH_FRACTION_BITS = 8;
  localparam int ANGLE_BITS = 11;
  localparam int ANGLE_FULL = 1800;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 11;
  localparam logic [CFG_IDX_BITS-1:0] REG_CALIBRATED = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLAT       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BENT       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DIFF   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_LEN    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ON_ANGLE   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFF_ANGLE  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_STABLE     = 3'd7;
endpackage
`default_nettype wire

>>> rtl/fbd_stream_if.sv
// Valid/ready stream interfaces for samples, results and register writes.
`default_nettype none
interface fbd_sample_if #(parameter int SAMPLE_BITS = 10);
  logic valid;
  logic ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fbd_result_if #(parameter int SAMPLE_BITS = 10);
  logic valid;
  logic ready;
  logic [SAMPLE_BITS-1:0] median_raw;
  logic [SAMPLE_BITS-1:0] filtered_raw;
  logic [10:0] angle_tenths;
  logic bent_state;
  modport source (output valid, output median_raw, output filtered_raw,
                  output angle_tenths, output bent_state, input ready);
  modport sink (input valid, input median_raw, input filtered_raw,
                input angle_tenths, input bent_state, output ready);
endinterface

interface fbd_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/flex_bend_detector_core.sv
// Top level: register file, sort-cell chain, smoother/divider and output register.
//
// channel   | dir | payload                                            | accepted when
// ----------+-----+----------------------------------------------------+---------------
// in_ch     | in  | sample                                             | valid & ready
// out_ch    | out | median_raw, filtered_raw, angle_tenths, bent_state | valid & ready
// cfg_ch    | in  | index (3b), data (11b)                             | valid & ready
//
// A sample that does not close a window is inserted into the sorted chain.
// A window-closing sample shows its result once the median is read out and the
// smoother, rounding and the bit-serial restoring divider of the angle have run.
// rst is synchronous; it restores register defaults and clears the filter.
// in_ch stalls from a window-closing transfer until its result has been taken.
// cfg_ch is always ready; a write to a listed register clears the filter state.
`default_nettype none
module flex_bend_detector_core #(
  parameter int MAX_WINDOW = fbd_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS = fbd_pkg::SAMPLE_BITS,
  parameter int SMOOTH_FRACTION_BITS = fbd_pkg::SMOOTH_FRACTION_BITS
) (
  input wire logic clk,
  input wire logic rst,
  fbd_sample_if.sink in_ch,
  fbd_result_if.source out_ch,
  fbd_cfg_if.sink cfg_ch
);
  import fbd_pkg::*;
  localparam int FW = $clog2(MAX_WINDOW + 1);

  // Configuration registers
  logic calibrated;
  logic [SAMPLE_BITS-1:0] flat_value, bent_value;
  logic [9:0] min_difference;
  logic [4:0] window_length;
  logic [10:0] on_angle, off_angle;
  logic [7:0] stable_count;
  logic cfg_hit;

  assign cfg_ch.ready = 1'b1;
  assign cfg_hit = cfg_ch.valid;  // every 3-bit index is a listed register

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated <= 1'b0;
      flat_value <= '0;
      bent_value <= '0;
      min_difference <= 10'd100;
      window_length <= 5'd5;
      on_angle <= 11'd900;
      off_angle <= 11'd700;
      stable_count <= 8'd3;
    end else if (cfg_hit) begin
      case (cfg_ch.index)
        REG_CALIBRATED: calibrated <= cfg_ch.data[0];
        REG_FLAT:       flat_value <= SAMPLE_BITS'(cfg_ch.data);
        REG_BENT:       bent_value <= SAMPLE_BITS'(cfg_ch.data);
        REG_MIN_DIFF:   min_difference <= cfg_ch.data[9:0];
        REG_WIN_LEN:    window_length <= cfg_ch.data[4:0];
        REG_ON_ANGLE:   on_angle <= cfg_ch.data;
        REG_OFF_ANGLE:  off_angle <= cfg_ch.data;
        REG_STABLE:     stable_count <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Gate: calibration must be valid
  logic [SAMPLE_BITS-1:0] spread;
  logic ready_cal;
  assign spread = (flat_value > bent_value) ? flat_value - bent_value
                                            : bent_value - flat_value;
  assign ready_cal = calibrated && (32'(spread) >= 32'(min_difference));

  // Effective window length
  logic [FW-1:0] n_eff;
  always_comb begin
    if (window_length == 5'd0) n_eff = FW'(1);
    else if (32'(window_length) > MAX_WINDOW) n_eff = FW'(MAX_WINDOW);
    else n_eff = FW'(window_length);
  end

  // Control
  logic busy;          // post unit working
  logic out_valid;
  logic [FW-1:0] fill;
  logic take;
  logic closes;
  logic post_done;
  logic [SAMPLE_BITS-1:0] median;
  logic [SAMPLE_BITS-1:0] filt;
  logic [10:0] ang;
  logic bstate;

  // Sort-cell chain
  logic [SAMPLE_BITS-1:0] cval [MAX_WINDOW];
  logic cfull [MAX_WINDOW];
  logic cgt [MAX_WINDOW];
  logic chain_clear;
  logic win_clear;

  // No transfer while the closed window is read out and cleared.
  assign in_ch.ready = !busy && !out_valid && !win_clear;
  assign take = in_ch.valid && in_ch.ready && ready_cal;
  assign closes = take && ((fill + FW'(1)) >= n_eff);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        // Missing left neighbor counts as full: cell 0 is the first free slot.
        fbd_sort_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
          .clk(clk), .clear(chain_clear), .insert(take), .new_val(in_ch.sample),
          .left_val('0), .left_full(1'b1), .left_greater(1'b0),
          .greater(cgt[gi]), .val(cval[gi]), .full(cfull[gi]));
      end else begin : g_rest
        fbd_sort_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
          .clk(clk), .clear(chain_clear), .insert(take), .new_val(in_ch.sample),
          .left_val(cval[gi-1]), .left_full(cfull[gi-1]), .left_greater(cgt[gi-1]),
          .greater(cgt[gi]), .val(cval[gi]), .full(cfull[gi]));
      end
    end
  endgenerate

  // Chain is cleared the cycle after a window closes (median captured then).
  assign chain_clear = rst || cfg_hit || win_clear;

  logic [FW-1:0] mid_idx;
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      fill <= '0;
      busy <= 1'b0;
      win_clear <= 1'b0;
    end else begin
      win_clear <= 1'b0;
      if (take) begin
        if (closes) begin
          fill <= '0;
          win_clear <= 1'b1;
          mid_idx <= n_eff >> 1;
        end else begin
          fill <= fill + FW'(1);
        end
      end
      if (win_clear) busy <= 1'b1;
      else if (post_done) busy <= 1'b0;
    end
  end

  // Median read out of the full chain at a fixed cycle.
  always_ff @(posedge clk) begin
    if (win_clear) median <= cval[mid_idx];
  end

  logic post_start;
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) post_start <= 1'b0;
    else post_start <= win_clear;
  end

  fbd_post #(.SAMPLE_BITS(SAMPLE_BITS), .SMOOTH_FRACTION_BITS(SMOOTH_FRACTION_BITS)) u_post (
    .clk(clk), .rst(rst), .clear(cfg_hit), .start(post_start), .median(median),
    .flat_value(flat_value), .bent_value(bent_value), .on_angle(on_angle),
    .off_angle(off_angle), .stable_count(stable_count), .done(post_done),
    .filtered_raw(filt), .angle_tenths(ang), .bent_state(bstate));

  // Output register
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      out_valid <= 1'b0;
    end else if (post_done) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_done) begin
      out_ch.median_raw <= median;
      out_ch.filtered_raw <= filt;
      out_ch.angle_tenths <= ang;
      out_ch.bent_state <= bstate;
    end
  end

  assign out_ch.valid = out_valid;
endmodule
`default_nettype wire

>>> rtl/fbd_sort_cell.sv
// One cell of the insertion-sort chain: holds one value, keeps the row ordered.
`default_nettype none
module fbd_sort_cell #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   clear,
  input  wire logic                   insert,
  input  wire logic [SAMPLE_BITS-1:0] new_val,
  input  wire logic [SAMPLE_BITS-1:0] left_val,
  input  wire logic                   left_full,
  input  wire logic                   left_greater,
  output logic                        greater,
  output logic [SAMPLE_BITS-1:0]      val,
  output logic                        full
);
  // Cell is "greater" if it holds a value strictly above the new one.
  assign greater = full && (val > new_val);

  always_ff @(posedge clk) begin
    if (clear) begin
      full <= 1'b0;
    end else if (insert) begin
      if (left_greater) begin
        val  <= left_val;
        full <= left_full;
      end else if (greater || (!full && left_full)) begin
        // first greater cell, or the first free cell of the row
        val  <= new_val;
        full <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/fbd_post.sv
// Smoother, iterative angle divider, hysteresis and debounce.
`default_nettype none
module fbd_post #(
  parameter int SAMPLE_BITS = fbd_pkg::SAMPLE_BITS,
  parameter int SMOOTH_FRACTION_BITS = fbd_pkg::SMOOTH_FRACTION_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   clear,
  input  wire logic                   start,
  input  wire logic [SAMPLE_BITS-1:0] median,
  input  wire logic [SAMPLE_BITS-1:0] flat_value,
  input  wire logic [SAMPLE_BITS-1:0] bent_value,
  input  wire logic [10:0]            on_angle,
  input  wire logic [10:0]            off_angle,
  input  wire logic [7:0]             stable_count,
  output logic                        done,
  output logic [SAMPLE_BITS-1:0]      filtered_raw,
  output logic [10:0]                 angle_tenths,
  output logic                        bent_state
);
  import fbd_pkg::*;
  localparam int SW = SAMPLE_BITS + SMOOTH_FRACTION_BITS;
  localparam int NW = SAMPLE_BITS + ANGLE_BITS;  // numerator width
  localparam int CW = $clog2(NW + 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RND  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [SW-1:0] smooth;
  logic loaded;
  logic [SAMPLE_BITS-1:0] raw;
  logic [NW-1:0] quo;
  logic [SAMPLE_BITS:0] rem;
  logic [SAMPLE_BITS-1:0] den;
  logic zero_ang;
  logic [CW-1:0] cnt;
  logic cand;
  logic [7:0] run;

  logic [SW+1:0] smooth_sum;
  logic [SW:0] rnd_sum;
  logic [SAMPLE_BITS:0] rem_sh;
  logic [NW-1:0] quo_clamp;
  logic [10:0] ang;
  logic meas;
  logic [7:0] run_inc;

  assign smooth_sum = 2'd3 * {2'b00, smooth} + {2'b00, median, {SMOOTH_FRACTION_BITS{1'b0}}};
  assign rnd_sum = {1'b0, smooth} + (SW+1)'(1 << (SMOOTH_FRACTION_BITS - 1));
  assign rem_sh = {rem[SAMPLE_BITS-1:0], quo[NW-1]};
  assign quo_clamp = (quo > NW'(ANGLE_FULL)) ? NW'(ANGLE_FULL) : quo;
  assign ang = zero_ang ? 11'd0 : quo_clamp[10:0];
  assign meas = bent_state ? (ang > off_angle) : (ang >= on_angle);
  assign run_inc = run + 8'd1;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state <= ST_IDLE;
      loaded <= 1'b0;
      smooth <= '0;
      bent_state <= 1'b0;
      cand <= 1'b0;
      run <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (!loaded) smooth <= {median, {SMOOTH_FRACTION_BITS{1'b0}}};
            else smooth <= smooth_sum[SW+1:2];
            loaded <= 1'b1;
            state <= ST_RND;
          end
        end
        ST_RND: begin
          // Round, saturate, set up the restoring divide.
          if (rnd_sum[SW:SMOOTH_FRACTION_BITS] > (SAMPLE_BITS+1)'({SAMPLE_BITS{1'b1}}))
            raw <= '1;
          else
            raw <= rnd_sum[SMOOTH_FRACTION_BITS +: SAMPLE_BITS];
          state <= ST_DIV;
          cnt <= '0;
          rem <= '0;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            if (bent_value > flat_value) begin
              zero_ang <= (raw <= flat_value);
              quo <= NW'(raw - flat_value) * NW'(ANGLE_FULL);
              den <= bent_value - flat_value;
            end else begin
              zero_ang <= (bent_value == flat_value) || (raw >= flat_value);
              quo <= NW'(flat_value - raw) * NW'(ANGLE_FULL);
              den <= flat_value - bent_value;
            end
            cnt <= CW'(1);
          end else begin
            // One quotient bit per cycle.
            if (rem_sh >= {1'b0, den}) begin
              rem <= rem_sh - {1'b0, den};
              quo <= {quo[NW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[NW-2:0], 1'b0};
            end
            if (cnt == CW'(NW)) state <= ST_FIN;
            cnt <= cnt + CW'(1);
          end
        end
        ST_FIN: begin
          angle_tenths <= ang;
          filtered_raw <= raw;
          if (meas == bent_state) begin
            cand <= bent_state;
            run <= '0;
          end else if (meas != cand) begin
            cand <= meas;
            run <= 8'd1;
          end else if (run_inc >= stable_count) begin
            bent_state <= cand;
            run <= '0;
          end else begin
            run <= run_inc;
          end
          done <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/fbd_checker.sv
// Port-level checker for the flex bend detector, bound to the top level.
`default_nettype none
`include "flex_bend_detector_core_defines.svh"
module fbd_port_props (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [10:0] angle,
  input wire logic cfg_valid
);
  `FBD_ASSERT_IMP(a_angle_range, out_valid, angle <= 11'd1800, "angle out of range")
  `FBD_ASSERT_IMP(a_no_in_while_out, out_valid, !in_ready, "input taken with result pending")
  `FBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready && !cfg_valid, out_valid, "result dropped")
  `FBD_ASSERT_NEXT(a_cfg_clears, cfg_valid, !out_valid, "config did not clear result")
endmodule

bind flex_bend_detector_core fbd_port_props u_fbd_port_props (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .angle(out_ch.angle_tenths),
  .cfg_valid(cfg_ch.valid));
`default_nettype wire
